### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("bipool: assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bipool: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bipool: assertion failed");

`endif

### rtl/core/bipool_pkg.sv
package bipool_pkg;

    localparam int ID_W     = 4;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam int DEF_NUM_BUFFERS = 16;
    localparam int DEF_RING_DEPTH  = 26;

    typedef logic [ID_W-1:0] t_id;

    typedef enum logic [CMD_W-1:0] {
        CMD_TAKE_FREE    = 3'd0,
        CMD_SUBMIT       = 3'd1,
        CMD_TAKE_FILLED  = 3'd2,
        CMD_RETURN_FREE  = 3'd3,
        CMD_MARK_DONE    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FINISHED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // input transfer: latch command, read both ring heads
        logic commit;   // execute the latched command and load the result
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } t_dp_status;

endpackage

### rtl/core/buffer_id_pool_two_rings_unit.sv
// Channel   Direction  tdata                   tuser
// s_axis    in         [3:0] buffer_id         [2:0] command
// m_axis    out        [3:0] granted_id        [1:0] status, [2] complete
//
// Each command has two phases: the transfer cycle reads both ring heads from
// their memories, then the command executes and loads the result register as
// soon as that register is free; no new command is taken before it executes.
// A result waiting on m_axis does not block the next input transfer; execution
// of that next command waits only until the result register frees up.
// Reset is synchronous; the preloaded free ids are tracked, not written.
`include "assert_macros.svh"

module buffer_id_pool_two_rings_unit #(
    parameter int NUM_BUFFERS = bipool_pkg::DEF_NUM_BUFFERS,
    parameter int RING_DEPTH  = bipool_pkg::DEF_RING_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] buffer_id, [7:4] zero
    input  logic [2:0] s_axis_tuser,   // [2:0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] granted_id, [7:4] zero
    output logic [2:0] m_axis_tuser    // [1:0] status, [2] complete
);

    bipool_pkg::t_ctrl_cmd  ctrl_cmd;
    bipool_pkg::t_dp_status dp_sts;

    bipool_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    bipool_dpath #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctrl_cmd),
        .o_sts      (dp_sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

    // A command never commits while an untaken result still sits in the register.
    `ASSERT_IMPLIES(a_commit_needs_room, i_clk, i_rst_n, ctrl_cmd.commit, !m_axis_tvalid || m_axis_tready)
    // Accepting and executing are separate phases of one command.
    `ASSERT_ALWAYS(a_no_accept_and_commit, i_clk, i_rst_n, !(ctrl_cmd.accept && ctrl_cmd.commit))
    // After an input transfer the block holds off further input until it executes.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, ctrl_cmd.accept, !s_axis_tready)
    // Every commit produces a result in the following cycle.
    `ASSERT_NEXT(a_result_after_commit, i_clk, i_rst_n, ctrl_cmd.commit, m_axis_tvalid)

endmodule

### rtl/core/bipool_ctrl.sv
module bipool_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  bipool_pkg::t_dp_status i_sts,
    output bipool_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready   = (r_state == S_IDLE);
    assign o_cmd.accept = i_s_tvalid && (r_state == S_IDLE);
    assign o_cmd.commit = (r_state == S_EXEC) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/bipool_dpath.sv
module bipool_dpath #(
    parameter int NUM_BUFFERS = bipool_pkg::DEF_NUM_BUFFERS,
    parameter int RING_DEPTH  = bipool_pkg::DEF_RING_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bipool_pkg::t_ctrl_cmd  i_cmd,
    output bipool_pkg::t_dp_status o_sts,
    input  logic [7:0]             i_s_tdata,
    input  logic [2:0]             i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_m_tdata,
    output logic [2:0]             o_m_tuser
);

    localparam int PW      = $clog2(RING_DEPTH);
    localparam int PRELOAD = (NUM_BUFFERS > RING_DEPTH - 1) ? RING_DEPTH - 1 : NUM_BUFFERS;
    localparam logic [PW-1:0] LAST_P     = PW'(RING_DEPTH - 1);
    localparam logic [PW-1:0] PRE_P      = PW'(PRELOAD);
    localparam logic [PW-1:0] PRE_LAST_P = PW'(PRELOAD - 1);

    bipool_pkg::t_id free_mem [RING_DEPTH];
    bipool_pkg::t_id fill_mem [RING_DEPTH];

    logic [PW-1:0]   r_free_head, r_free_tail, r_fill_head, r_fill_tail;
    logic [PW-1:0]   n_free_head, n_free_tail, n_fill_head, n_fill_tail;
    logic            r_done, n_done;
    // Preload tracking: the free ring starts with ids in its low slots without
    // writing the memory. Those slots read as their own index until the tail
    // has wrapped once and passed over them.
    logic            r_wrapped, n_wrapped;
    logic            r_pre_done, n_pre_done;

    logic [bipool_pkg::CMD_W-1:0] r_cmd;
    bipool_pkg::t_id r_bid;
    bipool_pkg::t_id r_free_rd, r_fill_rd;

    logic            r_out_valid;
    bipool_pkg::t_id r_out_id, n_out_id;
    bipool_pkg::t_status r_out_status, n_out_status;
    logic            r_out_complete;

    logic            free_we, fill_we;
    logic            free_empty, free_full, fill_empty, fill_full, free_pre;
    logic [PW-1:0]   free_head_nx, free_tail_nx, fill_head_nx, fill_tail_nx;
    bipool_pkg::t_id free_data;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == LAST_P) ? '0 : p + 1'b1;
    endfunction

    assign free_head_nx = ring_next(r_free_head);
    assign free_tail_nx = ring_next(r_free_tail);
    assign fill_head_nx = ring_next(r_fill_head);
    assign fill_tail_nx = ring_next(r_fill_tail);

    assign free_empty = (r_free_head == r_free_tail);
    assign free_full  = (free_tail_nx == r_free_head);
    assign fill_empty = (r_fill_head == r_fill_tail);
    assign fill_full  = (fill_tail_nx == r_fill_head);

    assign free_pre  = (r_free_head < PRE_P) && !r_pre_done
                       && (!r_wrapped || (r_free_head >= r_free_tail));
    assign free_data = free_pre ? bipool_pkg::t_id'(r_free_head) : r_free_rd;

    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_free_head  = r_free_head;
        n_free_tail  = r_free_tail;
        n_fill_head  = r_fill_head;
        n_fill_tail  = r_fill_tail;
        n_done       = r_done;
        n_wrapped    = r_wrapped;
        n_pre_done   = r_pre_done;
        n_out_id     = '0;
        n_out_status = bipool_pkg::ST_OK;
        free_we      = 1'b0;
        fill_we      = 1'b0;
        case (bipool_pkg::t_cmd'(r_cmd))
            bipool_pkg::CMD_TAKE_FREE: begin
                if (free_empty) begin
                    n_out_status = bipool_pkg::ST_EMPTY;
                end else begin
                    n_out_id    = free_data;
                    n_free_head = free_head_nx;
                end
            end
            bipool_pkg::CMD_SUBMIT: begin
                if (fill_full) begin
                    n_out_status = bipool_pkg::ST_FULL;
                end else begin
                    fill_we     = 1'b1;
                    n_fill_tail = fill_tail_nx;
                end
            end
            bipool_pkg::CMD_TAKE_FILLED: begin
                if (fill_empty) begin
                    n_out_status = r_done ? bipool_pkg::ST_FINISHED : bipool_pkg::ST_EMPTY;
                end else begin
                    n_out_id    = r_fill_rd;
                    n_fill_head = fill_head_nx;
                end
            end
            bipool_pkg::CMD_RETURN_FREE: begin
                if (free_full) begin
                    n_out_status = bipool_pkg::ST_FULL;
                end else begin
                    free_we     = 1'b1;
                    n_free_tail = free_tail_nx;
                    if (free_tail_nx == '0) begin
                        n_wrapped = 1'b1;
                    end
                    if (r_wrapped && (r_free_tail == PRE_LAST_P)) begin
                        n_pre_done = 1'b1;
                    end
                end
            end
            bipool_pkg::CMD_MARK_DONE: begin
                n_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Both heads are read on every input transfer; pointers do not move until
    // the command commits, so the read data stays valid while it waits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd     <= i_s_tuser[bipool_pkg::CMD_W-1:0];
            r_bid     <= i_s_tdata[bipool_pkg::ID_W-1:0];
            r_free_rd <= free_mem[r_free_head];
            r_fill_rd <= fill_mem[r_fill_head];
        end
        if (i_cmd.commit && free_we) begin
            free_mem[r_free_tail] <= r_bid;
        end
        if (i_cmd.commit && fill_we) begin
            fill_mem[r_fill_tail] <= r_bid;
        end
        if (i_cmd.commit) begin
            r_out_id       <= n_out_id;
            r_out_status   <= n_out_status;
            r_out_complete <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_free_tail <= PRE_P;
            r_fill_head <= '0;
            r_fill_tail <= '0;
            r_done      <= 1'b0;
            r_wrapped   <= 1'b0;
            r_pre_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free_head <= n_free_head;
                r_free_tail <= n_free_tail;
                r_fill_head <= n_fill_head;
                r_fill_tail <= n_fill_tail;
                r_done      <= n_done;
                r_wrapped   <= n_wrapped;
                r_pre_done  <= n_pre_done;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(8 - bipool_pkg::ID_W){1'b0}}, r_out_id};
    assign o_m_tuser  = {r_out_complete, r_out_status};

endmodule
